// ===== sv/packed_histogram_asymmetry_unit_macros.svh =====
// Assertion macros for the packed histogram asymmetry unit.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PACKED_HISTOGRAM_ASYMMETRY_UNIT_MACROS_SVH
`define PACKED_HISTOGRAM_ASYMMETRY_UNIT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define PHAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define PHAU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/phau_pkg.sv =====
// Shared constants, types and width helpers of the packed histogram asymmetry unit.
// No dependencies.
`timescale 1ns / 1ps

package phau_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int INDEX_BITS_DEF = 16;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int PACK_W         = 13;
  localparam int FILL_W         = 12;
  localparam int MAX_PACKING    = 4096;
  localparam int FRAC_BITS      = 8;
  localparam int BG_W           = 32;
  localparam int TZ_W           = 16;
  localparam int ERR_W          = 32;
  localparam int ASYM_STEPS     = 30;
  localparam int ERR_SHIFT      = 70;
  localparam int ONE_SIDE_SHIFT = 39;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PACKING   = 3'd0,
    CFG_FIRST_BIN = 3'd1,
    CFG_TIME_ZERO = 3'd2,
    CFG_BG_FWD    = 3'd3,
    CFG_BG_BWD    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // per-bin value magnitude bound, in bits
  function automatic int mx_w(int cb);
    return (cb + FRAC_BITS > BG_W) ? cb + FRAC_BITS : BG_W;
  endfunction

  // magnitude of a group sum (and of F+B), variance sums too
  function automatic int mag_w(int cb);
    return mx_w(cb) + FILL_W + 1;
  endfunction

  // signed group sums
  function automatic int sum_w(int cb);
    return mag_w(cb) + 1;
  endfunction

  // B^2 VF + F^2 VB
  function automatic int prod_w(int cb);
    return 3 * mag_w(cb) + 1;
  endfunction

  // bits of the integer square root of the shifted product
  function automatic int root_w(int cb);
    return (prod_w(cb) + ERR_SHIFT + 1) >> 1;
  endfunction

  function automatic int queue_w(int cb, int ib);
    return ib + 1 + 2 * sum_w(cb) + 2 * mag_w(cb) + PACK_W;
  endfunction

endpackage

// ===== sv/packed_histogram_asymmetry_unit.sv =====
// Packed histogram asymmetry unit. Bin items are accepted at one per cycle while
// the queue is not full and summed into groups; each finished group goes through
// a two-entry queue to a sequential back end. The back end takes a group, runs the
// asymmetry divide, five bit-serial multiplies, a bit-serial square root and the
// error divide, then loads the result register, where the result may wait behind
// a stalled output. A zero sum skips the multiplies, root and error divide, and a
// group with one side empty skips the multiplies and root. Input stalls only while
// the queue holds two groups, so groups longer than the back-end latency stream
// freely.
`timescale 1ns / 1ps
`include "packed_histogram_asymmetry_unit_macros.svh"

module packed_histogram_asymmetry_unit #(
  parameter int COUNT_BITS = phau_pkg::COUNT_BITS_DEF,
  parameter int INDEX_BITS = phau_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [phau_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [phau_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             start_of_run_i,
  input  logic [COUNT_BITS-1:0]            forward_count_i,
  input  logic [COUNT_BITS-1:0]            backward_count_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [INDEX_BITS:0]       time_bins_o,
  output logic signed [31:0]               asymmetry_o,
  output logic [31:0]                      asymmetry_error_o,
  output logic                             saturated_o
);

  localparam int QW = phau_pkg::queue_w(COUNT_BITS, INDEX_BITS);

  phau_pkg::cfg_wr_t cfg;
  logic              q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]     q_wdata, q_rdata;
  logic              asym_ok, err_max;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  phau_front #(
    .COUNT_BITS (COUNT_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_of_run_i   (start_of_run_i),
    .forward_count_i  (forward_count_i),
    .backward_count_i (backward_count_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_data_o         (q_wdata)
  );

  phau_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  phau_back #(
    .COUNT_BITS (COUNT_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_data_i          (q_rdata),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .time_bins_o       (time_bins_o),
    .asymmetry_o       (asymmetry_o),
    .asymmetry_error_o (asymmetry_error_o),
    .saturated_o       (saturated_o)
  );

  assign asym_ok = (asymmetry_o <= 32'sh4000_0000) && (asymmetry_o >= -32'sh4000_0000);
  assign err_max = asymmetry_error_o == '1;

  `PHAU_ASSERT_NEVER(a_queue_overflow, q_push && q_full, "group pushed into full queue")
  `PHAU_ASSERT_IMP(a_sat_all_ones, out_valid_o && saturated_o, err_max, "saturated error not max")
  `PHAU_ASSERT_IMP(a_asym_range, out_valid_o, asym_ok, "asymmetry beyond one")

endmodule

// ===== sv/phau_front.sv =====
// Front end: configuration registers, bin accumulation and group closing.
// Depends on phau_pkg; pushes finished groups into phau_queue.
`timescale 1ns / 1ps

module phau_front #(
  parameter int COUNT_BITS = phau_pkg::COUNT_BITS_DEF,
  parameter int INDEX_BITS = phau_pkg::INDEX_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  phau_pkg::cfg_wr_t       cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    start_of_run_i,
  input  logic [COUNT_BITS-1:0]   forward_count_i,
  input  logic [COUNT_BITS-1:0]   backward_count_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output logic [phau_pkg::queue_w(COUNT_BITS, INDEX_BITS)-1:0] q_data_o
);

  localparam int MW = phau_pkg::mag_w(COUNT_BITS);
  localparam int SW = phau_pkg::sum_w(COUNT_BITS);
  localparam int PW = phau_pkg::PACK_W;
  localparam int FW = phau_pkg::FILL_W;
  localparam int TW = ((INDEX_BITS > phau_pkg::TZ_W) ? INDEX_BITS : phau_pkg::TZ_W) + 2;
  localparam logic signed [TW-1:0] T_MAX = TW'((1 << INDEX_BITS) - 1);
  localparam logic signed [TW-1:0] T_MIN = -T_MAX - TW'(1);

  logic [PW-1:0]              packing_q;
  logic [phau_pkg::TZ_W-1:0]  first_bin_q, tz_q;
  logic [phau_pkg::BG_W-1:0]  bgf_q, bgb_q;
  logic [INDEX_BITS-1:0]      idx_q, idx_d;
  logic [FW-1:0]              fill_q, fill_d;
  logic                       open_q;
  logic signed [SW-1:0]       fsum_q, fsum_d, bsum_q, bsum_d;
  logic [MW-1:0]              fvar_q, fvar_d, bvar_q, bvar_d;

  logic [PW-1:0]         p_eff;
  logic                  accept, emit, restart;
  logic [MW-1:0]         fc, bc;
  logic [PW-1:0]         fill_inc;
  logic signed [TW-1:0]  t_raw, t_sat;

  always_comb begin
    if (packing_q == '0) begin
      p_eff = PW'(1);
    end else if (packing_q > PW'(phau_pkg::MAX_PACKING)) begin
      p_eff = PW'(phau_pkg::MAX_PACKING);
    end else begin
      p_eff = packing_q;
    end
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  // a group closes when the first bin of the next one arrives
  assign emit       = open_q && (fill_q == '0) && !start_of_run_i;
  assign restart    = start_of_run_i || emit;
  assign q_push_o   = accept && emit;

  assign fc = MW'(forward_count_i) << phau_pkg::FRAC_BITS;
  assign bc = MW'(backward_count_i) << phau_pkg::FRAC_BITS;

  assign t_raw = $signed(TW'(idx_q)) - $signed(TW'(tz_q)) - $signed(TW'(p_eff));

  always_comb begin
    if (t_raw < T_MIN) begin
      t_sat = T_MIN;
    end else if (t_raw > T_MAX) begin
      t_sat = T_MAX;
    end else begin
      t_sat = t_raw;
    end
  end

  assign q_data_o = {t_sat[INDEX_BITS:0], fsum_q, bsum_q, fvar_q, bvar_q, p_eff};

  assign fill_inc = PW'(fill_q) + PW'(1);

  always_comb begin
    fsum_d = (restart ? '0 : fsum_q) + $signed(SW'(fc)) - $signed(SW'(bgf_q));
    bsum_d = (restart ? '0 : bsum_q) + $signed(SW'(bc)) - $signed(SW'(bgb_q));
    fvar_d = (restart ? '0 : fvar_q) + fc + MW'(bgf_q);
    bvar_d = (restart ? '0 : bvar_q) + bc + MW'(bgb_q);
    fill_d = start_of_run_i ? FW'(1) : fill_inc[FW-1:0];
    if (start_of_run_i) begin
      if (PW'(1) >= p_eff) begin
        fill_d = '0;
      end
    end else if (fill_inc >= p_eff) begin
      fill_d = '0;
    end
    idx_d = (start_of_run_i ? INDEX_BITS'(first_bin_q) : idx_q) + INDEX_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packing_q   <= PW'(1);
      first_bin_q <= '0;
      tz_q        <= '0;
      bgf_q       <= '0;
      bgb_q       <= '0;
    end else if (cfg_i.we) begin
      case (phau_pkg::cfg_idx_e'(cfg_i.index))
        phau_pkg::CFG_PACKING:   packing_q   <= cfg_i.data[PW-1:0];
        phau_pkg::CFG_FIRST_BIN: first_bin_q <= cfg_i.data[phau_pkg::TZ_W-1:0];
        phau_pkg::CFG_TIME_ZERO: tz_q        <= cfg_i.data[phau_pkg::TZ_W-1:0];
        phau_pkg::CFG_BG_FWD:    bgf_q       <= cfg_i.data[phau_pkg::BG_W-1:0];
        phau_pkg::CFG_BG_BWD:    bgb_q       <= cfg_i.data[phau_pkg::BG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      fill_q <= '0;
      open_q <= 1'b0;
      fsum_q <= '0;
      bsum_q <= '0;
      fvar_q <= '0;
      bvar_q <= '0;
    end else if (accept) begin
      idx_q  <= idx_d;
      fill_q <= fill_d;
      open_q <= 1'b1;
      fsum_q <= fsum_d;
      bsum_q <= bsum_d;
      fvar_q <= fvar_d;
      bvar_q <= bvar_d;
    end
  end

endmodule

// ===== sv/phau_queue.sv =====
// Two-entry queue of closed groups between front and back end.
// No dependencies; generic width.
`timescale 1ns / 1ps

module phau_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

endmodule

// ===== sv/phau_back.sv =====
// Back end: per-group asymmetry and error, iterative divide, multiply and root.
// Depends on phau_pkg; takes groups from phau_queue, holds the result register.
`timescale 1ns / 1ps

module phau_back #(
  parameter int COUNT_BITS = phau_pkg::COUNT_BITS_DEF,
  parameter int INDEX_BITS = phau_pkg::INDEX_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  logic [phau_pkg::queue_w(COUNT_BITS, INDEX_BITS)-1:0] q_data_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [INDEX_BITS:0] time_bins_o,
  output logic signed [31:0]      asymmetry_o,
  output logic [31:0]             asymmetry_error_o,
  output logic                    saturated_o
);

  localparam int MW  = phau_pkg::mag_w(COUNT_BITS);
  localparam int SW  = phau_pkg::sum_w(COUNT_BITS);
  localparam int PW  = phau_pkg::prod_w(COUNT_BITS);
  localparam int RW  = phau_pkg::root_w(COUNT_BITS);
  localparam int NW  = 2 * RW;
  localparam int DW  = 2 * MW;
  localparam int YW  = (RW > phau_pkg::PACK_W + phau_pkg::ONE_SIDE_SHIFT) ?
                       RW : phau_pkg::PACK_W + phau_pkg::ONE_SIDE_SHIFT;
  localparam int CW  = ((YW > DW + phau_pkg::ERR_W) ? YW : DW + phau_pkg::ERR_W) + 1;
  localparam int SCW = $clog2(RW + 1);
  localparam int EW  = phau_pkg::ERR_W;

  typedef enum logic [7:0] {
    BK_IDLE = 8'b0000_0001,
    BK_ASYM = 8'b0000_0010,
    BK_MSET = 8'b0000_0100,
    BK_MRUN = 8'b0000_1000,
    BK_SQRT = 8'b0001_0000,
    BK_DSET = 8'b0010_0000,
    BK_DIV  = 8'b0100_0000,
    BK_DONE = 8'b1000_0000
  } bk_state_e;

  typedef enum logic [2:0] {
    MS_BB = 3'd0,
    MS_XF = 3'd1,
    MS_FF = 3'd2,
    MS_XB = 3'd3,
    MS_SS = 3'd4
  } mul_step_e;

  bk_state_e state_q, state_d;
  mul_step_e mstep_q, mstep_d;

  // queue entry fields
  logic [INDEX_BITS:0]        t_w;
  logic signed [SW-1:0]       f_w, b_w, s_w, dv_w;
  logic [MW-1:0]              vf_w, vb_w, fm_w, bm_w, sm_w, dm_w;
  logic [phau_pkg::PACK_W-1:0] p_w;

  assign {t_w, f_w, b_w, vf_w, vb_w, p_w} = q_data_i;
  assign s_w  = f_w + b_w;
  assign dv_w = f_w - b_w;
  assign fm_w = f_w[SW-1] ? MW'(-f_w) : MW'(f_w);
  assign bm_w = b_w[SW-1] ? MW'(-b_w) : MW'(b_w);
  assign sm_w = s_w[SW-1] ? MW'(-s_w) : MW'(s_w);
  assign dm_w = dv_w[SW-1] ? MW'(-dv_w) : MW'(dv_w);

  logic [INDEX_BITS:0]  time_q, time_d;
  logic                 neg_q, neg_d, szero_q, szero_d;
  logic [MW-1:0]        fm_q, fm_d, bm_q, bm_d, sm_q, sm_d, vf_q, vf_d, vb_q, vb_d;
  logic [phau_pkg::PACK_W-1:0] p_q, p_d;
  logic [MW-1:0]        ar_q, ar_d;
  logic [30:0]          aq_q, aq_d;
  logic [4:0]           acnt_q, acnt_d;
  logic [31:0]          asym_q, asym_d;
  logic [PW-1:0]        ma_q, ma_d, macc_q, macc_d, x_q, x_d;
  logic [MW-1:0]        mb_q, mb_d;
  logic [DW-1:0]        tmp_q, tmp_d, d_q, d_d;
  logic [NW-1:0]        sn_q, sn_d;
  logic [RW+1:0]        sr_q, sr_d;
  logic [RW-1:0]        root_q, root_d;
  logic [SCW-1:0]       scnt_q, scnt_d;
  logic [CW-1:0]        y_q, y_d, dsh_q, dsh_d;
  logic [EW-1:0]        dq_q, dq_d, err_q, err_d;
  logic [4:0]           dcnt_q, dcnt_d;
  logic                 sat_q, sat_d;

  logic                 ovld_q, ovld_d;
  logic [INDEX_BITS:0]  otime_q, otime_d;
  logic [31:0]          oasym_q, oasym_d, oerr_q, oerr_d;
  logic                 osat_q, osat_d;

  logic [MW:0]          ar_sh;
  logic                 a_bit;
  logic [RW+1:0]        rr, trial;
  logic                 d_bit;
  logic [31:0]          asym_fin;

  assign ar_sh    = {ar_q, 1'b0};
  assign a_bit    = ar_sh >= (MW + 1)'(sm_q);
  assign rr       = {sr_q[RW-1:0], sn_q[NW-1:NW-2]};
  assign trial    = {root_q, 2'b01};
  assign d_bit    = y_q >= dsh_q;
  assign asym_fin = neg_q ? (32'd0 - 32'(aq_q)) : 32'(aq_q);
  assign q_pop_o  = (state_q == BK_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    mstep_d = mstep_q;
    time_d = time_q;   neg_d = neg_q;   szero_d = szero_q;
    fm_d = fm_q;       bm_d = bm_q;     sm_d = sm_q;
    vf_d = vf_q;       vb_d = vb_q;     p_d = p_q;
    ar_d = ar_q;       aq_d = aq_q;     acnt_d = acnt_q;   asym_d = asym_q;
    ma_d = ma_q;       mb_d = mb_q;     macc_d = macc_q;
    x_d = x_q;         tmp_d = tmp_q;   d_d = d_q;
    sn_d = sn_q;       sr_d = sr_q;     root_d = root_q;   scnt_d = scnt_q;
    y_d = y_q;         dsh_d = dsh_q;   dq_d = dq_q;       dcnt_d = dcnt_q;
    err_d = err_q;     sat_d = sat_q;
    ovld_d = ovld_q && out_stall_i;
    otime_d = otime_q; oasym_d = oasym_q; oerr_d = oerr_q; osat_d = osat_q;

    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          time_d  = t_w;
          neg_d   = s_w[SW-1] ^ dv_w[SW-1];
          szero_d = s_w == '0;
          fm_d = fm_w;  bm_d = bm_w;  sm_d = sm_w;
          vf_d = vf_w;  vb_d = vb_w;  p_d = p_w;
          ar_d = dm_w;
          aq_d = '0;
          acnt_d = '0;
          // zero terms give zero; a ratio beyond one clips to one
          if (s_w == '0 || dv_w == '0) begin
            acnt_d = 5'(phau_pkg::ASYM_STEPS);
          end else if (dm_w >= sm_w) begin
            aq_d   = 31'(phau_pkg::Q30_ONE);
            acnt_d = 5'(phau_pkg::ASYM_STEPS);
          end
          state_d = BK_ASYM;
        end
      end
      BK_ASYM: begin
        if (acnt_q == 5'(phau_pkg::ASYM_STEPS)) begin
          asym_d = asym_fin;
          if (szero_q) begin
            err_d   = phau_pkg::Q30_ONE;
            sat_d   = 1'b0;
            state_d = BK_DONE;
          end else if (fm_q == '0 || bm_q == '0) begin
            // one side empty: error = 2^39 p / |other side|
            y_d     = CW'(p_q) << phau_pkg::ONE_SIDE_SHIFT;
            d_d     = DW'((fm_q == '0) ? bm_q : fm_q);
            state_d = BK_DSET;
          end else begin
            mstep_d = MS_BB;
            state_d = BK_MSET;
          end
        end else begin
          ar_d   = a_bit ? MW'(ar_sh - (MW + 1)'(sm_q)) : ar_sh[MW-1:0];
          aq_d   = {aq_q[29:0], a_bit};
          acnt_d = acnt_q + 5'd1;
        end
      end
      BK_MSET: begin
        macc_d = '0;
        unique case (mstep_q)
          MS_BB: begin ma_d = PW'(bm_q);  mb_d = bm_q; end
          MS_XF: begin ma_d = PW'(tmp_q); mb_d = vf_q; end
          MS_FF: begin ma_d = PW'(fm_q);  mb_d = fm_q; end
          MS_XB: begin ma_d = PW'(tmp_q); mb_d = vb_q; macc_d = x_q; end
          MS_SS: begin ma_d = PW'(sm_q);  mb_d = sm_q; end
          default: begin ma_d = '0; mb_d = '0; end
        endcase
        state_d = BK_MRUN;
      end
      BK_MRUN: begin
        if (mb_q == '0) begin
          state_d = BK_MSET;
          unique case (mstep_q)
            MS_BB: begin tmp_d = DW'(macc_q); mstep_d = MS_XF; end
            MS_XF: begin x_d = macc_q;        mstep_d = MS_FF; end
            MS_FF: begin tmp_d = DW'(macc_q); mstep_d = MS_XB; end
            MS_XB: begin x_d = macc_q;        mstep_d = MS_SS; end
            MS_SS: begin
              d_d     = DW'(macc_q);
              sn_d    = NW'(x_q) << phau_pkg::ERR_SHIFT;
              sr_d    = '0;
              root_d  = '0;
              scnt_d  = '0;
              state_d = BK_SQRT;
            end
            default: state_d = BK_IDLE;
          endcase
        end else begin
          if (mb_q[0]) begin
            macc_d = macc_q + ma_q;
          end
          ma_d = ma_q << 1;
          mb_d = mb_q >> 1;
        end
      end
      BK_SQRT: begin
        if (scnt_q == SCW'(RW)) begin
          y_d     = CW'(root_q);
          state_d = BK_DSET;
        end else begin
          if (rr >= trial) begin
            sr_d   = rr - trial;
            root_d = {root_q[RW-2:0], 1'b1};
          end else begin
            sr_d   = rr;
            root_d = {root_q[RW-2:0], 1'b0};
          end
          sn_d   = sn_q << 2;
          scnt_d = scnt_q + SCW'(1);
        end
      end
      BK_DSET: begin
        if (y_q >= (CW'(d_q) << EW)) begin
          err_d   = '1;
          sat_d   = 1'b1;
          state_d = BK_DONE;
        end else begin
          dsh_d   = CW'(d_q) << (EW - 1);
          dq_d    = '0;
          dcnt_d  = '0;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (d_bit) begin
          y_d = y_q - dsh_q;
        end
        dsh_d  = dsh_q >> 1;
        dq_d   = {dq_q[EW-2:0], d_bit};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'(EW - 1)) begin
          err_d   = {dq_q[EW-2:0], d_bit};
          sat_d   = 1'b0;
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d  = 1'b1;
          otime_d = time_q;
          oasym_d = asym_q;
          oerr_d  = err_q;
          osat_d  = sat_q;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      mstep_q <= MS_BB;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;   neg_q <= neg_d;   szero_q <= szero_d;
    fm_q <= fm_d;       bm_q <= bm_d;     sm_q <= sm_d;
    vf_q <= vf_d;       vb_q <= vb_d;     p_q <= p_d;
    ar_q <= ar_d;       aq_q <= aq_d;     acnt_q <= acnt_d;   asym_q <= asym_d;
    ma_q <= ma_d;       mb_q <= mb_d;     macc_q <= macc_d;
    x_q <= x_d;         tmp_q <= tmp_d;   d_q <= d_d;
    sn_q <= sn_d;       sr_q <= sr_d;     root_q <= root_d;   scnt_q <= scnt_d;
    y_q <= y_d;         dsh_q <= dsh_d;   dq_q <= dq_d;       dcnt_q <= dcnt_d;
    err_q <= err_d;     sat_q <= sat_d;
    otime_q <= otime_d; oasym_q <= oasym_d; oerr_q <= oerr_d; osat_q <= osat_d;
  end

  assign out_valid_o       = ovld_q;
  assign time_bins_o       = $signed(otime_q);
  assign asymmetry_o       = $signed(oasym_q);
  assign asymmetry_error_o = oerr_q;
  assign saturated_o       = osat_q;

endmodule

// ===== sim/asymmetry_checker.sv =====
// Checker for the packed histogram asymmetry unit: watches the register port and
// both channels, predicts each group result and compares it field by field.
// Depends on phau_pkg.
`timescale 1ns / 1ps

module asymmetry_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [phau_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [phau_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              start_of_run_i,
  input  logic [23:0]                       forward_count_i,
  input  logic [23:0]                       backward_count_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [16:0]                time_bins_i,
  input  logic signed [31:0]                asymmetry_i,
  input  logic [31:0]                       asymmetry_error_i,
  input  logic                              saturated_i,
  output int                                fail_count_o,
  output int                                groups_waiting_o,
  output int                                groups_checked_o
);

  typedef struct {
    logic signed [16:0] time_bins;
    logic [31:0]        asym;
    logic [31:0]        err;
    logic               sat;
  } group_result_t;

  group_result_t expected_groups[$];

  // register copies
  logic [12:0] packing_q;
  logic [15:0] first_bin_q, time_zero_q;
  logic [31:0] bg_fwd_q, bg_bwd_q;

  // group state; sums are Q8
  logic [15:0]     bin_idx;
  int unsigned     fill;
  bit              grp_open;
  longint          fwd_sum, bwd_sum;
  longint unsigned fwd_var, bwd_var;

  assign groups_waiting_o = expected_groups.size();

  function automatic bit [255:0] root_floor(input bit [255:0] x);
    bit [255:0] r, c;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      c = r | (256'd1 << i);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic group_result_t predict_group(input logic [15:0] idx, input int unsigned p);
    group_result_t   g;
    longint          t, s, dv;
    longint unsigned sm, dm, fm, bm, q;
    bit [255:0]      x, y, d;
    t = longint'(idx) - longint'(time_zero_q) - longint'(p);
    if (t < -65536) t = -65536;
    if (t > 65535) t = 65535;
    g.time_bins = t[16:0];
    s  = fwd_sum + bwd_sum;
    dv = fwd_sum - bwd_sum;
    sm = (s < 0) ? -s : s;
    dm = (dv < 0) ? -dv : dv;
    fm = (fwd_sum < 0) ? -fwd_sum : fwd_sum;
    bm = (bwd_sum < 0) ? -bwd_sum : bwd_sum;
    if (s == 0 || dv == 0) q = 0;
    else if (dm >= sm) q = 64'd1 << 30;
    else begin
      // the shifted difference needs more than 64 bits
      x = (256'(dm) << 30) / 256'(sm);
      q = x[63:0];
    end
    g.asym = ((s < 0) != (dv < 0)) ? 32'(-q) : 32'(q);
    g.sat = 1'b0;
    if (s == 0) begin
      g.err = phau_pkg::Q30_ONE;
    end else if (fm == 0 || bm == 0) begin
      // one side empty: error is 2^39 p / |other side|
      q = (longint'(p) << 39) / ((fm == 0) ? bm : fm);
      if (q > 64'hFFFF_FFFF) begin
        g.err = '1;
        g.sat = 1'b1;
      end else g.err = q[31:0];
    end else begin
      x = (256'(bm) * 256'(bm) * 256'(fwd_var) + 256'(fm) * 256'(fm) * 256'(bwd_var)) << 70;
      y = root_floor(x);
      d = 256'(sm) * 256'(sm);
      if (y >= (d << 32)) begin
        g.err = '1;
        g.sat = 1'b1;
      end else begin
        x = y / d;
        g.err = x[31:0];
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned   p;
    longint        fc, bc;
    group_result_t g;
    int            errs;
    if (!rst_ni) begin
      packing_q   <= 13'd1;
      first_bin_q <= '0;
      time_zero_q <= '0;
      bg_fwd_q    <= '0;
      bg_bwd_q    <= '0;
      bin_idx = '0;
      fill = 0;
      grp_open = 0;
      fwd_sum = 0; bwd_sum = 0; fwd_var = 0; bwd_var = 0;
      expected_groups.delete();
      fail_count_o <= 0;
      groups_checked_o <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (phau_pkg::cfg_idx_e'(cfg_index_i))
          phau_pkg::CFG_PACKING:   packing_q   <= cfg_data_i[12:0];
          phau_pkg::CFG_FIRST_BIN: first_bin_q <= cfg_data_i[15:0];
          phau_pkg::CFG_TIME_ZERO: time_zero_q <= cfg_data_i[15:0];
          phau_pkg::CFG_BG_FWD:    bg_fwd_q    <= cfg_data_i;
          phau_pkg::CFG_BG_BWD:    bg_bwd_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        p = (packing_q == 0) ? 1 :
            (packing_q > phau_pkg::MAX_PACKING) ? phau_pkg::MAX_PACKING : packing_q;
        if (start_of_run_i) begin
          bin_idx = first_bin_q;
          fill = 0;
          grp_open = 0;
          fwd_sum = 0; bwd_sum = 0; fwd_var = 0; bwd_var = 0;
        end
        if (grp_open && fill == 0) begin
          expected_groups.insert(expected_groups.size(), predict_group(bin_idx, p));
          fwd_sum = 0; bwd_sum = 0; fwd_var = 0; bwd_var = 0;
        end
        fc = longint'(forward_count_i) << 8;
        bc = longint'(backward_count_i) << 8;
        fwd_sum += fc - longint'(bg_fwd_q);
        bwd_sum += bc - longint'(bg_bwd_q);
        fwd_var += fc + bg_fwd_q;
        bwd_var += bc + bg_bwd_q;
        grp_open = 1;
        fill++;
        if (fill >= p) fill = 0;
        bin_idx = bin_idx + 16'd1;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_groups.size() == 0) begin
          $error("result item with no group waiting");
          errs++;
        end else begin
          g = expected_groups.pop_front();
          groups_checked_o <= groups_checked_o + 1;
          if (time_bins_i !== g.time_bins) begin
            $error("time_bins: expected %0d, got %0d", g.time_bins, time_bins_i);
            errs++;
          end
          if (asymmetry_i !== g.asym) begin
            $error("asymmetry: expected %0d, got %0d", $signed(g.asym), asymmetry_i);
            errs++;
          end
          if (asymmetry_error_i !== g.err) begin
            $error("asymmetry_error: expected %0h, got %0h", g.err, asymmetry_error_i);
            errs++;
          end
          if (saturated_i !== g.sat) begin
            $error("saturated: expected %0b, got %0b", g.sat, saturated_i);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        fail_count_o <= fail_count_o + errs;
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the packed histogram asymmetry unit testbench: clock, reset, register
// writes, bin stimulus and verdict. Depends on phau_pkg, the unit and asymmetry_checker.
`timescale 1ns / 1ps

module testbench;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [phau_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [phau_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           start_of_run = 1'b0;
  logic [23:0]                    fwd_count = '0, bwd_count = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [16:0]             time_bins;
  logic signed [31:0]             asymmetry;
  logic [31:0]                    asymmetry_error;
  logic                           saturated;
  int                             fail_count, groups_waiting, groups_checked;
  int                             items_sent = 0;
  int                             burst_left = 0;
  int                             stall_mode = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  packed_histogram_asymmetry_unit DUT (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .start_of_run_i(start_of_run),
    .forward_count_i(fwd_count), .backward_count_i(bwd_count),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .time_bins_o(time_bins), .asymmetry_o(asymmetry),
    .asymmetry_error_o(asymmetry_error), .saturated_o(saturated)
  );

  asymmetry_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .start_of_run_i(start_of_run),
    .forward_count_i(fwd_count), .backward_count_i(bwd_count),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .time_bins_i(time_bins), .asymmetry_i(asymmetry),
    .asymmetry_error_i(asymmetry_error), .saturated_i(saturated),
    .fail_count_o(fail_count), .groups_waiting_o(groups_waiting),
    .groups_checked_o(groups_checked)
  );

  // receiver stall pattern: switches between free, light and heavy stalling
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic write_reg(input phau_pkg::cfg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // drive one bin item; called just after a falling edge
  task automatic send_bin(input logic sor, input logic [23:0] f, input logic [23:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid     <= 1'b1;
    start_of_run <= sor;
    fwd_count    <= f;
    bwd_count    <= b;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    @(negedge clk_i);
  endtask

  // stop sending and let every outstanding group drain
  task automatic drain_groups();
    in_valid <= 1'b0;
    while (groups_waiting != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 24'($urandom_range(0, 15));
      3:       return 24'($urandom_range(0, 4095));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_background();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return $urandom_range(0, 4095);
      2:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [23:0] c;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: default packing, sum zero, one side empty, extremes, restart
    send_bin(0, 24'd0, 24'd0);
    send_bin(0, 24'd0, 24'd0);
    send_bin(0, '1, 24'd0);
    send_bin(0, 24'd0, '1);
    send_bin(0, 24'd1234, 24'd1234);
    send_bin(0, '1, '1);
    send_bin(1, 24'd5, 24'd3);
    send_bin(0, 24'd1, 24'd2);
    send_bin(0, 24'd7, 24'd0);
    drain_groups();
    // background beyond the counts, packing zero, index near wrap
    write_reg(phau_pkg::CFG_PACKING, 32'd0);
    write_reg(phau_pkg::CFG_BG_FWD, 32'h0001_0000);
    write_reg(phau_pkg::CFG_BG_BWD, 32'hFFFF_FFFF);
    write_reg(phau_pkg::CFG_FIRST_BIN, 32'h0000_FFFE);
    write_reg(phau_pkg::CFG_TIME_ZERO, 32'h0000_FFFF);
    send_bin(1, 24'd3, 24'd9);
    send_bin(0, 24'd300, 24'd0);
    send_bin(0, '1, 24'd1);
    send_bin(0, 24'd0, '1);
    send_bin(0, 24'd2, 24'd2);
    drain_groups();
    // packing changed while a group is open
    write_reg(phau_pkg::CFG_PACKING, 32'd3);
    write_reg(phau_pkg::CFG_BG_BWD, 32'd0);
    write_reg(phau_pkg::CFG_TIME_ZERO, 32'd0);
    send_bin(1, 24'd10, 24'd20);
    send_bin(0, 24'd30, 24'd40);
    drain_groups();
    write_reg(phau_pkg::CFG_PACKING, 32'd2);
    send_bin(0, 24'd50, 24'd60);
    send_bin(0, 24'd70, 24'd80);
    send_bin(0, 24'd90, 24'd15);
    drain_groups();

    // random phases, mostly short groups
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(phau_pkg::CFG_PACKING, $urandom_range(0, 3) == 0 ? $urandom_range(4, 16)
                                                                  : $urandom_range(0, 3));
      write_reg(phau_pkg::CFG_FIRST_BIN, $urandom_range(0, 2) == 0 ?
                $urandom_range(65500, 65535) : $urandom_range(0, 65535));
      write_reg(phau_pkg::CFG_TIME_ZERO, $urandom_range(0, 65535));
      write_reg(phau_pkg::CFG_BG_FWD, pick_background());
      write_reg(phau_pkg::CFG_BG_BWD, pick_background());
      for (int i = 0; i < 193; i++) begin
        c = pick_count();
        send_bin($urandom_range(0, 29) == 0, pick_count(),
                 $urandom_range(0, 7) == 0 ? c : pick_count());
      end
      drain_groups();
    end

    // largest packing, and a value beyond it that clamps: the packing is
    // widened just before a closed group is reported
    write_reg(phau_pkg::CFG_PACKING, 32'd1);
    write_reg(phau_pkg::CFG_BG_FWD, 32'd100);
    send_bin(1, pick_count(), pick_count());
    drain_groups();
    write_reg(phau_pkg::CFG_PACKING, 32'd4096);
    send_bin(0, pick_count(), pick_count());
    drain_groups();
    write_reg(phau_pkg::CFG_PACKING, 32'd1);
    send_bin(0, pick_count(), pick_count());
    drain_groups();
    write_reg(phau_pkg::CFG_PACKING, 32'd8191);
    send_bin(0, pick_count(), pick_count());
    drain_groups();

    $display("Sent %0d bin items under directed and random register settings;",
             items_sent);
    $display("%0d group results checked, with bursts, pauses and output stalls.",
             groups_checked);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
